### design/wsd_pkg.sv
// wsd_pkg: types and constants shared by the websocket deframer modules
// depends on nothing
`default_nettype none
package wsd_pkg;

  // parser phase codes; unused codes are treated as the first header byte
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_PING  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // protocol error causes
  localparam logic [2:0] CAUSE_UNMASKED    = 3'd0;
  localparam logic [2:0] CAUSE_RESERVED    = 3'd1;
  localparam logic [2:0] CAUSE_OPCODE      = 3'd2;
  localparam logic [2:0] CAUSE_CONTROL     = 3'd3;
  localparam logic [2:0] CAUSE_STRAY_CONT  = 3'd4;
  localparam logic [2:0] CAUSE_INTERLEAVED = 3'd5;

  // frame opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // 7-bit length codes
  localparam logic [6:0] LEN7_CTRL_MAX = 7'd125;
  localparam logic [6:0] LEN7_EXT16    = 7'd126;
  localparam logic [6:0] LEN7_EXT64    = 7'd127;

  // extended length bytes still to come after the first one
  localparam logic [2:0] EXT16_COUNT = 3'd1;
  localparam logic [2:0] EXT64_COUNT = 3'd7;

  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       data_valid;
    logic       last;
    logic       msg_type;
    logic [2:0] error_cause;
  } result_t;

  typedef struct packed {
    logic closed;
  } front_stat_t;

  typedef struct packed {
    logic                     full;
    logic [QUEUE_LEVEL_W-1:0] level;
  } queue_stat_t;

endpackage
`default_nettype wire

### design/websocket_frame_deframer.sv
// websocket_frame_deframer: top level of the receive-side frame deframer
// depends on wsd_pkg, wsd_front, wsd_queue, wsd_back
//
// Receive-side websocket deframer. One client byte is taken per clock on the
// in channel while the event queue has room; the header (flags, opcode,
// 7/16/64-bit length, mask key) is decoded on the fly and payload bytes are
// unmasked and streamed out, one result per byte where one is due. Text and
// binary bytes leave as kind 0 with msg_type and last; ping payload leaves as
// kind 1 for a pong echo; pong frames and close payload are dropped. A close
// frame (kind 2, answer 1000) or a protocol error (kind 3 with error_cause,
// answer 1002) gives a single event, after which all input is taken and
// ignored until reset. A result reaches the out port through a four-entry
// event queue and then an output register, so the in side keeps running
// while the out side is stalled until the queue fills. Lengths wider than
// LENGTH_BITS saturate to all ones.
`default_nettype none
module websocket_frame_deframer import wsd_pkg::*; #(
  parameter int LENGTH_BITS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // byte input channel
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] in_byte,
  // result channel
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic [1:0] kind,
  output      logic [7:0] data,
  output      logic       data_valid,
  output      logic       last,
  output      logic       msg_type,
  output      logic [2:0] error_cause
);

  result_t     push_item;
  result_t     head;
  result_t     out_item;
  logic        push;
  logic        pop;
  logic        nonempty;
  front_stat_t front_stat;
  queue_stat_t queue_stat;

  // front: parses every accepted byte and classifies it into at most one event
  wsd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .queue_full(queue_stat.full),
    .push      (push),
    .push_item (push_item),
    .stat      (front_stat)
  );

  // queue: decouples byte intake from result delivery
  wsd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .nonempty (nonempty),
    .stat     (queue_stat)
  );

  // back: registered result transfer
  wsd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .nonempty (nonempty),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  assign kind        = out_item.kind;
  assign data        = out_item.data;
  assign data_valid  = out_item.data_valid;
  assign last        = out_item.last;
  assign msg_type    = out_item.msg_type;
  assign error_cause = out_item.error_cause;

`ifndef SYNTHESIS
  // once closed, the connection stays closed until reset
  a_closed_sticky: assert property (@(posedge clk) disable iff (rst)
    front_stat.closed |=> front_stat.closed)
    else $error("closed flag dropped without reset");

  // the parser never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !queue_stat.full)
    else $error("event pushed into full queue");

  // queue occupancy never goes past its depth
  a_level_bounded: assert property (@(posedge clk) disable iff (rst)
    queue_stat.level <= QUEUE_LEVEL_W'(QUEUE_DEPTH))
    else $error("queue level beyond its depth");

  // close and error events carry no byte and no end mark
  a_end_events_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_ERROR || kind == KIND_CLOSE) |-> !data_valid && !last)
    else $error("close or error event carries payload fields");

  // only message data carries a message type
  a_type_only_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> !msg_type)
    else $error("msg_type set on a non-data event");
`endif

endmodule
`default_nettype wire

### design/wsd_front.sv
// wsd_front: header parser, unmasking and event classification per byte
// depends on wsd_pkg
`default_nettype none
module wsd_front import wsd_pkg::*; #(
  parameter int LENGTH_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        queue_full,
  output      logic        push,
  output      result_t     push_item,
  output      front_stat_t stat
);

  phase_t                 phase, phase_next;
  logic                   frame_final, frame_final_next;
  logic [3:0]             frame_opcode, frame_opcode_next;
  logic                   rsv_seen, rsv_seen_next;
  logic [2:0]             len_count, len_count_next;
  logic [LENGTH_BITS-1:0] remaining, remaining_next;
  logic                   len_ovf, len_ovf_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [1:0]             mask_pos, mask_pos_next;
  logic                   in_fragment, in_fragment_next;
  logic                   fragment_type, fragment_type_next;
  logic                   closed, closed_next;

  logic                   go;
  logic [6:0]             len7;
  logic                   known_op;
  logic                   hdr1_err;
  logic [2:0]             hdr1_cause;
  logic                   hend_err;
  logic [2:0]             hend_cause;
  logic                   rem_zero;
  logic                   pay_end;
  logic                   cur_type;
  logic [LENGTH_BITS-1:0] ext_shifted;
  logic                   ext_ovf;
  logic [7:0]             unmasked;
  logic                   emit;
  result_t                item;

  assign in_stall  = queue_full;
  assign go        = in_valid && !in_stall && !closed;
  assign push      = go && emit;
  assign push_item = item;
  assign stat.closed = closed;

  // decisions shared by the phase and datapath logic
  assign len7     = in_byte[6:0];
  assign known_op = (frame_opcode == OP_CONT) || (frame_opcode == OP_TEXT) ||
                    (frame_opcode == OP_BINARY) || (frame_opcode == OP_CLOSE) ||
                    (frame_opcode == OP_PING) || (frame_opcode == OP_PONG);
  assign rem_zero = (remaining == '0);
  assign pay_end  = (remaining[LENGTH_BITS-1:1] == '0);
  assign cur_type = (frame_opcode == OP_CONT) ? fragment_type : (frame_opcode == OP_BINARY);
  assign ext_shifted = {remaining[LENGTH_BITS-9:0], in_byte};
  assign ext_ovf     = len_ovf || (remaining[LENGTH_BITS-1 -: 8] != 8'd0);

  always_comb begin
    case (mask_pos)
      2'd0:    unmasked = in_byte ^ mask_key[31:24];
      2'd1:    unmasked = in_byte ^ mask_key[23:16];
      2'd2:    unmasked = in_byte ^ mask_key[15:8];
      default: unmasked = in_byte ^ mask_key[7:0];
    endcase
  end

  always_comb begin
    hdr1_err   = 1'b1;
    hdr1_cause = CAUSE_UNMASKED;
    if (!in_byte[7]) begin
      hdr1_cause = CAUSE_UNMASKED;
    end else if (rsv_seen) begin
      hdr1_cause = CAUSE_RESERVED;
    end else if (!known_op) begin
      hdr1_cause = CAUSE_OPCODE;
    end else if (frame_opcode[3] && (!frame_final || len7 > LEN7_CTRL_MAX)) begin
      hdr1_cause = CAUSE_CONTROL;
    end else begin
      hdr1_err = 1'b0;
    end
  end

  always_comb begin
    hend_err   = 1'b0;
    hend_cause = CAUSE_STRAY_CONT;
    if (frame_opcode == OP_CONT) begin
      hend_err = !in_fragment;
    end else if (frame_opcode == OP_TEXT || frame_opcode == OP_BINARY) begin
      hend_err   = in_fragment;
      hend_cause = CAUSE_INTERLEAVED;
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (go) begin
      case (phase)
        PH_HDR1: begin
          if (!hdr1_err) begin
            phase_next = (len7 >= LEN7_EXT16) ? PH_EXTLEN : PH_MASK;
          end
        end
        PH_EXTLEN: begin
          if (len_count == 3'd0) phase_next = PH_MASK;
        end
        PH_MASK: begin
          if (mask_pos == 2'd3 && !hend_err) begin
            phase_next = rem_zero ? PH_HDR0 : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (pay_end) phase_next = PH_HDR0;
        end
        default: phase_next = PH_HDR1;
      endcase
    end
  end

  // datapath and emitted event
  always_comb begin
    frame_final_next   = frame_final;
    frame_opcode_next  = frame_opcode;
    rsv_seen_next      = rsv_seen;
    len_count_next     = len_count;
    remaining_next     = remaining;
    len_ovf_next       = len_ovf;
    mask_key_next      = mask_key;
    mask_pos_next      = mask_pos;
    in_fragment_next   = in_fragment;
    fragment_type_next = fragment_type;
    closed_next        = closed;
    emit               = 1'b0;
    item               = '0;
    if (go) begin
      case (phase)
        PH_HDR1: begin
          if (hdr1_err) begin
            closed_next      = 1'b1;
            emit             = 1'b1;
            item.kind        = KIND_ERROR;
            item.error_cause = hdr1_cause;
          end else begin
            mask_pos_next = 2'd0;
            mask_key_next = '0;
            len_ovf_next  = 1'b0;
            if (len7 == LEN7_EXT16) begin
              len_count_next = EXT16_COUNT;
              remaining_next = '0;
            end else if (len7 == LEN7_EXT64) begin
              len_count_next = EXT64_COUNT;
              remaining_next = '0;
            end else begin
              len_count_next = 3'd0;
              remaining_next = {{(LENGTH_BITS-7){1'b0}}, len7};
            end
          end
        end
        PH_EXTLEN: begin
          len_ovf_next = ext_ovf;
          if (len_count == 3'd0) begin
            remaining_next = ext_ovf ? '1 : ext_shifted;
          end else begin
            remaining_next = ext_shifted;
            len_count_next = len_count - 3'd1;
          end
        end
        PH_MASK: begin
          mask_key_next = {mask_key[23:0], in_byte};
          if (mask_pos == 2'd3) begin
            mask_pos_next = 2'd0;
            if (hend_err) begin
              closed_next      = 1'b1;
              emit             = 1'b1;
              item.kind        = KIND_ERROR;
              item.error_cause = hend_cause;
            end else begin
              if (frame_opcode == OP_CONT) begin
                if (frame_final) in_fragment_next = 1'b0;
              end else if (frame_opcode == OP_TEXT || frame_opcode == OP_BINARY) begin
                if (!frame_final) begin
                  in_fragment_next   = 1'b1;
                  fragment_type_next = (frame_opcode == OP_BINARY);
                end
              end
              // empty frame ends right at the header
              if (rem_zero) begin
                if (frame_opcode == OP_CONT || frame_opcode == OP_TEXT ||
                    frame_opcode == OP_BINARY) begin
                  emit          = frame_final;
                  item.kind     = KIND_DATA;
                  item.last     = 1'b1;
                  item.msg_type = cur_type;
                end else if (frame_opcode == OP_PING) begin
                  emit      = 1'b1;
                  item.kind = KIND_PING;
                  item.last = 1'b1;
                end else if (frame_opcode == OP_CLOSE) begin
                  closed_next = 1'b1;
                  emit        = 1'b1;
                  item.kind   = KIND_CLOSE;
                end
              end
            end
          end else begin
            mask_pos_next = mask_pos + 2'd1;
          end
        end
        PH_PAYLOAD: begin
          mask_pos_next = mask_pos + 2'd1;
          if (!rem_zero) remaining_next = remaining - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
          if (frame_opcode == OP_CONT || frame_opcode == OP_TEXT ||
              frame_opcode == OP_BINARY) begin
            emit            = 1'b1;
            item.kind       = KIND_DATA;
            item.data       = unmasked;
            item.data_valid = 1'b1;
            item.last       = pay_end && frame_final;
            item.msg_type   = cur_type;
          end else if (frame_opcode == OP_PING) begin
            emit            = 1'b1;
            item.kind       = KIND_PING;
            item.data       = unmasked;
            item.data_valid = 1'b1;
            item.last       = pay_end;
          end else if (frame_opcode == OP_CLOSE && pay_end) begin
            closed_next = 1'b1;
            emit        = 1'b1;
            item.kind   = KIND_CLOSE;
          end
        end
        default: begin
          frame_final_next  = in_byte[7];
          rsv_seen_next     = (in_byte[6:4] != 3'd0);
          frame_opcode_next = in_byte[3:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR0;
      frame_final   <= 1'b0;
      frame_opcode  <= OP_CONT;
      rsv_seen      <= 1'b0;
      len_count     <= 3'd0;
      mask_pos      <= 2'd0;
      in_fragment   <= 1'b0;
      fragment_type <= 1'b0;
      closed        <= 1'b0;
    end else begin
      phase         <= phase_next;
      frame_final   <= frame_final_next;
      frame_opcode  <= frame_opcode_next;
      rsv_seen      <= rsv_seen_next;
      len_count     <= len_count_next;
      mask_pos      <= mask_pos_next;
      in_fragment   <= in_fragment_next;
      fragment_type <= fragment_type_next;
      closed        <= closed_next;
    end
  end

  always_ff @(posedge clk) begin
    remaining <= remaining_next;
    len_ovf   <= len_ovf_next;
    mask_key  <= mask_key_next;
  end

endmodule
`default_nettype wire

### design/wsd_queue.sv
// wsd_queue: short event queue between the parser and the output stage
// depends on wsd_pkg
`default_nettype none
module wsd_queue import wsd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_item,
  input  wire logic    pop,
  output      result_t head,
  output      logic    nonempty,
  output queue_stat_t  stat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  result_t                  mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]         wr_ptr, rd_ptr;
  logic [QUEUE_LEVEL_W-1:0] level, level_next;
  logic                     do_push, do_pop;

  assign do_push    = push && !stat.full;
  assign do_pop     = pop && nonempty;
  assign nonempty   = (level != '0);
  assign stat.full  = (level == QUEUE_LEVEL_W'(QUEUE_DEPTH));
  assign stat.level = level;
  assign head       = mem[rd_ptr];

  always_comb begin
    level_next = level;
    if (do_push && !do_pop) level_next = level + QUEUE_LEVEL_W'(1);
    if (do_pop && !do_push) level_next = level - QUEUE_LEVEL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + PTR_W'(1);
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_item;
  end

endmodule
`default_nettype wire

### design/wsd_back.sv
// wsd_back: output register that drains the event queue onto the result channel
// depends on wsd_pkg
`default_nettype none
module wsd_back import wsd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire result_t head,
  input  wire logic    nonempty,
  output      logic    pop,
  output      logic    out_valid,
  input  wire logic    out_stall,
  output      result_t out_item
);

  // load when the register is empty or its transfer completes this cycle
  assign pop = nonempty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_item <= head;
  end

endmodule
`default_nettype wire
